FILE: hw/rtl/mbrf_pkg.sv
// ============================================================================
// Modbus RTU request framer package
// Shared types and constants for the framer front end, command queue and
// result back end.
// ============================================================================
package mbrf_pkg;

	// Default size of the frame store in bytes.
	localparam int BUFFER_BYTES_DEF = 64;

	// Width of a frame length; a variable frame may be up to 9 + 255 bytes long.
	localparam int NEED_W = 9;

	// Frame layout.
	localparam int HDR_BYTES      = 7;  // address, function, two words, byte count
	localparam int PAYLOAD_OFS    = 7;  // first payload byte of codes 15 and 16
	localparam int FIXED_LEN      = 8;  // frame length of codes 1 to 6
	localparam int VAR_BASE       = 9;  // frame length of codes 15 and 16 without payload
	localparam int UNKNOWN_MIN    = 4;  // bytes held before an unknown code is dropped

	// Function codes.
	localparam logic [7:0] FC_FIXED_LO  = 8'd1;
	localparam logic [7:0] FC_FIXED_HI  = 8'd6;
	localparam logic [7:0] FC_WR_COILS  = 8'd15;
	localparam logic [7:0] FC_WR_REGS   = 8'd16;

	// CRC-16 of the RTU framing.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_CRC_ERR = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	// One finished frame, handed from the front end to the back end.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  dev_addr;
		logic [7:0]  func_code;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic [7:0]  payload_count;
	} cmd_t;

	// One result on the output stream.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  dev_addr;
		logic [7:0]  func_code;
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic [7:0]  payload_count;
		logic [7:0]  data_byte;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_PAY
	} back_state_t;

endpackage

FILE: hw/rtl/mbrf_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module mbrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/mbrf_front.sv
// ============================================================================
// Framer front end
// Stores received bytes, runs the CRC, tracks the frame length and queues a
// command for every frame that completes or has an unknown function code.
// ============================================================================
module mbrf_front
	import mbrf_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	input  logic                            gap_expired,
	input  logic                            queue_full,
	input  logic                            pay_done,
	output logic                            push,
	output cmd_t                            cmd,
	output logic                            wr_en,
	output logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
	output logic [7:0]                      wr_data
);

	localparam int FW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(BUFFER_BYTES);

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [FW-1:0]     fill_q;
	logic [15:0]       crc_q;
	logic              lock_q;
	logic [7:0]        hdr_q [HDR_BYTES];
	logic [7:0]        b1_q;
	logic [7:0]        b2_q;

	logic              accept;
	logic [FW-1:0]     fill_eff;
	logic [FW-1:0]     fill_new;
	logic [15:0]       crc_eff;
	logic [15:0]       crc_new;
	logic [7:0]        hdr_n [HDR_BYTES];
	logic              is_fixed;
	logic              is_var;
	logic [NEED_W-1:0] need;
	logic              unk_hit;
	logic              done_hit;
	logic              overflow;
	logic              crc_ok;
	logic              clear;

	// A good frame with payload locks the store until the back end has read it.
	assign in_ready = !queue_full && !lock_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		fill_eff = gap_expired ? '0 : fill_q;
		fill_new = fill_eff + FW'(1);
		crc_eff  = gap_expired ? CRC_INIT : crc_q;
		// The CRC trails the store by two bytes, which hold the received CRC.
		crc_new  = (fill_eff >= FW'(2)) ? crc_fold(crc_eff, b2_q) : crc_eff;
		for (int i = 0; i < HDR_BYTES; i++) begin
			hdr_n[i] = (fill_eff == FW'(i)) ? rx_byte : hdr_q[i];
		end

		is_fixed = (hdr_n[1] >= FC_FIXED_LO) && (hdr_n[1] <= FC_FIXED_HI);
		is_var   = (hdr_n[1] == FC_WR_COILS) || (hdr_n[1] == FC_WR_REGS);
		if (is_fixed) begin
			need = NEED_W'(FIXED_LEN);
		end else if (is_var && (fill_new >= FW'(HDR_BYTES))) begin
			need = NEED_W'(VAR_BASE) + {1'b0, hdr_n[6]};
		end else begin
			need = '0;
		end

		unk_hit  = !is_fixed && !is_var && (fill_new >= FW'(UNKNOWN_MIN));
		done_hit = (need != '0) && (NEED_W'(fill_new) == need);
		overflow = (fill_new == FW'(BUFFER_BYTES));
		crc_ok   = (crc_new == {rx_byte, b1_q});
		clear    = unk_hit || done_hit || overflow;
		push     = accept && (unk_hit || done_hit);

		cmd.dev_addr  = hdr_n[0];
		cmd.func_code = hdr_n[1];
		if (unk_hit) begin
			cmd.kind          = KIND_UNKNOWN;
			cmd.first_word    = '0;
			cmd.second_word   = '0;
			cmd.payload_count = '0;
		end else begin
			cmd.kind          = crc_ok ? KIND_HEADER : KIND_CRC_ERR;
			cmd.first_word    = {hdr_n[2], hdr_n[3]};
			cmd.second_word   = {hdr_n[4], hdr_n[5]};
			cmd.payload_count = is_var ? hdr_n[6] : '0;
		end
	end

	assign wr_en   = accept;
	assign wr_addr = fill_eff[AW-1:0];
	assign wr_data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q  <= CRC_INIT;
			lock_q <= 1'b0;
		end else begin
			if (accept) begin
				if (clear) begin
					fill_q <= '0;
					crc_q  <= CRC_INIT;
				end else begin
					fill_q <= fill_new;
					crc_q  <= crc_new;
				end
			end
			if (push && (cmd.kind == KIND_HEADER) && (cmd.payload_count != '0)) begin
				lock_q <= 1'b1;
			end else if (pay_done) begin
				lock_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr_q[i] <= hdr_n[i];
			end
			b1_q <= rx_byte;
			b2_q <= b1_q;
		end
	end

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FW'(BUFFER_BYTES))
		else $error("fill count reached the store size");

	a_no_accept_locked: assert property (@(posedge clk) disable iff (!arst_n)
		$past(push && (cmd.kind == KIND_HEADER) && (cmd.payload_count != '0)) |-> !accept)
		else $error("byte accepted while payload still unread");

endmodule

FILE: hw/rtl/mbrf_cmd_fifo.sv
// ============================================================================
// Command queue
// Two-entry queue of frame commands between the front end and back end.
// ============================================================================
module mbrf_cmd_fifo
	import mbrf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

endmodule

FILE: hw/rtl/mbrf_back.sv
// ============================================================================
// Framer back end
// Turns queued commands into results: one header, CRC error or discard result,
// then the payload bytes of a good frame read back from the frame store.
// ============================================================================
module mbrf_back
	import mbrf_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            empty,
	input  cmd_t                            head,
	output logic                            pop,
	output logic                            rd_en,
	output logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
	input  logic [7:0]                      rd_data,
	output logic                            pay_done,
	output logic                            out_valid,
	input  logic                            out_ready,
	output res_t                            out_res
);

	localparam int AW = $clog2(BUFFER_BYTES);

	back_state_t state_q;
	back_state_t state_n;
	logic [7:0]  idx_q;
	logic [7:0]  cnt_q;
	logic        valid_q;
	res_t        res_q;

	logic        slot_free;
	logic        load;
	res_t        res_n;
	logic        pay_last;
	logic [8:0]  rd_sum;

	assign slot_free = !valid_q || out_ready;
	assign pay_last  = (idx_q == cnt_q - 8'd1);
	assign rd_sum    = 9'(PAYLOAD_OFS) + {1'b0, idx_q};
	assign rd_addr   = rd_sum[AW-1:0];

	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE: begin
				if (!empty && slot_free && (head.kind == KIND_HEADER)
						&& (head.payload_count != '0)) begin
					state_n = B_RD;
				end
			end
			B_RD: begin
				state_n = B_PAY;
			end
			B_PAY: begin
				if (slot_free) begin
					state_n = pay_last ? B_IDLE : B_RD;
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		load     = 1'b0;
		pay_done = 1'b0;
		res_n    = '0;
		case (state_q)
			B_IDLE: begin
				if (!empty && slot_free) begin
					pop                 = 1'b1;
					load                = 1'b1;
					res_n.kind          = head.kind;
					res_n.dev_addr      = head.dev_addr;
					res_n.func_code     = head.func_code;
					res_n.first_word    = head.first_word;
					res_n.second_word   = head.second_word;
					res_n.payload_count = head.payload_count;
					res_n.last          = (head.kind != KIND_HEADER)
						|| (head.payload_count == '0);
				end
			end
			B_RD: begin
				rd_en = 1'b1;
			end
			B_PAY: begin
				if (slot_free) begin
					load            = 1'b1;
					res_n.kind      = KIND_PAYLOAD;
					res_n.data_byte = rd_data;
					res_n.last      = pay_last;
					pay_done        = pay_last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop) begin
				idx_q <= '0;
				cnt_q <= head.payload_count;
			end else if ((state_q == B_PAY) && slot_free) begin
				idx_q <= idx_q + 8'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_n;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	a_payload_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> (cnt_q != '0))
		else $error("payload read without a byte count");

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pay_done |=> (out_valid && out_res.last && (out_res.kind == KIND_PAYLOAD)))
		else $error("final payload result not marked last");

endmodule

FILE: hw/rtl/modbus_rtu_request_framer.sv
// ============================================================================
// Modbus RTU request framer
// Collects received serial bytes into RTU request frames, checks the CRC-16
// and emits a header, error or discard result, then any payload of a good frame.
// ============================================================================
// Input stream: one received byte per transfer in s_axis_tdata; s_axis_tuser
// flags that the inter-byte gap timer expired before the byte, which starts
// a new frame. Output stream: one result per transfer, kind in m_axis_tuser,
// tlast set on the final result of each frame. A byte that ends a frame has
// its header or error result written into the command queue and then loaded
// into the output register once the back end is idle and the output is free.
// Payload bytes of a good frame follow one at a time, each read back from the
// frame store through its registered read port; the input is held off until
// the last of them has been loaded into the output register. A two-entry
// command queue lets the front end keep taking bytes while a header result
// waits at the output.
// Reset empties the store and the queue and drops any result not yet taken;
// the store contents themselves are not cleared, so the block is ready the
// cycle after reset is released. When the receiver stalls, the output holds
// its result and the front end keeps taking bytes until the queue fills.
// Unknown function codes give one discard result after four bytes; a store
// that fills up without a complete frame is emptied without a result.
module modbus_rtu_request_framer
	import mbrf_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_axis_tuser,   // [0] gap_expired
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] dev_addr, [15:8] func_code, [31:16] first_word,
	// [47:32] second_word, [55:48] payload_count, [63:56] data_byte
	output logic [63:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast
);

	localparam int AW = $clog2(BUFFER_BYTES);

	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head;
	logic          full;
	logic          empty;
	logic          pay_done;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	res_t          res;

	mbrf_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.rx_byte     (s_axis_tdata),
		.gap_expired (s_axis_tuser[0]),
		.queue_full  (full),
		.pay_done    (pay_done),
		.push        (push),
		.cmd         (push_cmd),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	// Frame store: written by the front end, payload read by the back end.
	mbrf_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mbrf_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	mbrf_back #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.pay_done  (pay_done),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.data_byte, res.payload_count, res.second_word,
		res.first_word, res.func_code, res.dev_addr};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule
